>>> hw/rtl/bds_pkg.sv
// Shared types and constants for the 2x2 box downsampler.
package bds_pkg;

  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int ROW_BITS     = 11;
  localparam int FIELD_BITS   = 16;
  localparam int NUM_LANES    = 4;
  localparam int HEIGHT_LIMIT = 2048;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] in_ch0;
    logic [FIELD_BITS-1:0] in_ch1;
    logic [FIELD_BITS-1:0] in_ch2;
    logic [FIELD_BITS-1:0] in_ch3;
  } bds_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] out_ch0;
    logic [FIELD_BITS-1:0] out_ch1;
    logic [FIELD_BITS-1:0] out_ch2;
    logic [FIELD_BITS-1:0] out_ch3;
    logic                  frame_done;
  } bds_out_t;

  // Per-pixel position flags, from the counters to the lanes
  typedef struct packed {
    logic odd_col;     // pixel completes a horizontal pair
    logic single;      // even last column, no horizontal partner
    logic complete;    // horizontal sum is final for this pixel
    logic odd_row;     // second row of the block
    logic last_row;    // frame row with no vertical partner below
    logic emit;        // pixel produces an output
    logic frame_end;   // last pixel of the frame
  } bds_flags_t;

endpackage

>>> hw/rtl/box_downsample_2x2.sv
// 2x2 box downsampler: one averaged pixel per 2x2 block of a raster pixel stream.
// Pipeline: lane sums and flags are registered in stage one, then the result in the output register.
// Throughput: one pixel per cycle while not stalled; each lane's line buffer is read per pixel, written on even rows.
// Reset: counters to the frame origin, geometry to 2048x2048, pipeline emptied.
// The line buffers are not cleared; an odd row only reads entries its even row wrote.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH = 2048,
  parameter int CHANNELS  = 4,
  parameter int CHAN_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bds_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bds_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bds_pkg::bds_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bds_pkg::bds_out_t                out_data
);

  localparam int XW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int FB         = bds_pkg::FIELD_BITS;

  logic                  take;
  logic                  s1_valid;
  logic                  s1_move;
  bds_pkg::bds_flags_t   flags;
  bds_pkg::bds_flags_t   s1_flags;
  logic [AW-1:0]         addr;
  logic [FB-1:0]         chan_in  [bds_pkg::NUM_LANES];
  logic [FB-1:0]         chan_out [bds_pkg::NUM_LANES];
  bds_pkg::bds_out_t     merged;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign take      = in_valid && in_ready;

  assign chan_in[0] = in_data.in_ch0;
  assign chan_in[1] = in_data.in_ch1;
  assign chan_in[2] = in_data.in_ch2;
  assign chan_in[3] = in_data.in_ch3;

  bds_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .XW        (XW),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .flags     (flags),
    .addr      (addr)
  );

  // One lane per active channel; unused channels read as zero
  for (genvar c = 0; c < bds_pkg::NUM_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      logic [CHAN_BITS-1:0] res;
      bds_lane #(
        .CHAN_BITS  (CHAN_BITS),
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
      ) u_lane (
        .clk       (clk),
        .take      (take),
        .flags     (flags),
        .addr      (addr),
        .px        (chan_in[c][CHAN_BITS-1:0]),
        .res_flags (s1_flags),
        .res       (res)
      );
      assign chan_out[c] = FB'(res);
    end else begin : g_off
      assign chan_out[c] = '0;
    end
  end

  // Stage-one control: flags travel with the registered lane data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_flags <= flags;
    end
  end

  // Merge lane results into one output pixel
  always_comb begin
    merged.out_ch0    = chan_out[0];
    merged.out_ch1    = chan_out[1];
    merged.out_ch2    = chan_out[2];
    merged.out_ch3    = chan_out[3];
    merged.frame_done = s1_flags.frame_end;
  end

  // Output register; drop pixels that produce no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_flags.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_flags.emit) begin
      out_data <= merged;
    end
  end

endmodule

>>> hw/rtl/bds_ctrl.sv
// Geometry registers and column/row counters that classify each pixel.
module bds_ctrl #(
  parameter int MAX_WIDTH = 2048,
  parameter int XW        = 11,
  parameter int AW        = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bds_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bds_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                              take,
  output bds_pkg::bds_flags_t               flags,
  output logic [AW-1:0]                     addr
);

  localparam int WCMP = (XW + 1 > bds_pkg::CFG_BITS) ? XW + 1 : bds_pkg::CFG_BITS;
  localparam int HCMP = bds_pkg::CFG_BITS;

  logic [bds_pkg::CFG_BITS-1:0] frame_width;
  logic [bds_pkg::CFG_BITS-1:0] frame_height;
  logic [XW-1:0]                column_count;
  logic [bds_pkg::ROW_BITS-1:0] row_count;

  logic [WCMP-1:0] width_eff;
  logic [HCMP-1:0] height_eff;
  logic [WCMP-1:0] x_plus;
  logic [HCMP-1:0] y_plus;
  logic [XW-1:0]   x_half;
  logic            last_col;
  logic            last_row;

  // Clamp the geometry into its legal range
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WCMP'(1);
    end else if (WCMP'(frame_width) > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = WCMP'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = HCMP'(1);
    end else if (frame_height > HCMP'(bds_pkg::HEIGHT_LIMIT)) begin
      height_eff = HCMP'(bds_pkg::HEIGHT_LIMIT);
    end else begin
      height_eff = frame_height;
    end
  end

  // Classify the current pixel position
  always_comb begin
    x_plus   = WCMP'(column_count) + WCMP'(1);
    y_plus   = HCMP'(row_count) + HCMP'(1);
    last_col = (x_plus >= width_eff);
    last_row = (y_plus >= height_eff);
    x_half   = column_count >> 1;
    addr     = AW'(x_half);

    flags.odd_col   = column_count[0];
    flags.single    = !column_count[0] && last_col;
    flags.complete  = column_count[0] || last_col;
    flags.odd_row   = row_count[0];
    flags.last_row  = last_row;
    flags.emit      = (column_count[0] || last_col) && (row_count[0] || last_row);
    flags.frame_end = last_col && last_row;
  end

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bds_pkg::CFG_BITS'(2048);
      frame_height <= bds_pkg::CFG_BITS'(2048);
    end else if (cfg_valid) begin
      case (cfg_index)
        bds_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bds_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the raster position on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : bds_pkg::ROW_BITS'(y_plus);
      end else begin
        column_count <= XW'(x_plus);
      end
    end
  end

endmodule

>>> hw/rtl/bds_lane.sv
// One channel lane: pair hold, line buffer of horizontal sums, and the average.
module bds_lane #(
  parameter int CHAN_BITS  = 16,
  parameter int LINE_DEPTH = 1024,
  parameter int AW         = 10
) (
  input  logic                 clk,
  input  logic                 take,
  input  bds_pkg::bds_flags_t  flags,
  input  logic [AW-1:0]        addr,
  input  logic [CHAN_BITS-1:0] px,
  input  bds_pkg::bds_flags_t  res_flags,
  output logic [CHAN_BITS-1:0] res
);

  logic [CHAN_BITS-1:0] hold;
  logic [CHAN_BITS:0]   line_mem [LINE_DEPTH];
  logic [CHAN_BITS:0]   hsum;
  logic [CHAN_BITS:0]   hsum_q;
  logic [CHAN_BITS:0]   stored_q;
  logic [CHAN_BITS+1:0] vsum;
  logic                 line_wr;

  // Horizontal pair sum
  always_comb begin
    if (flags.odd_col) begin
      hsum = {1'b0, hold} + {1'b0, px};
    end else begin
      hsum = {1'b0, px};
    end
    line_wr = flags.complete && !flags.odd_row && !flags.last_row;
  end

  // Hold the even-column pixel and register the pair sum
  always_ff @(posedge clk) begin
    if (take) begin
      if (!flags.complete) begin
        hold <= px;
      end
      hsum_q <= hsum;
    end
  end

  // Line buffer: even rows other than the last write, odd rows read back
  always_ff @(posedge clk) begin
    if (take) begin
      if (line_wr) begin
        line_mem[addr] <= hsum;
      end
      stored_q <= line_mem[addr];
    end
  end

  // Vertical combine and truncating average
  always_comb begin
    vsum = {1'b0, stored_q} + {1'b0, hsum_q};
    if (res_flags.odd_row) begin
      res = res_flags.single ? vsum[CHAN_BITS:1] : vsum[CHAN_BITS+1:2];
    end else begin
      res = res_flags.single ? hsum_q[CHAN_BITS-1:0] : hsum_q[CHAN_BITS:1];
    end
  end

endmodule
